FILE: design/per_source_failure_window_ban_assert.svh
// Assertion macros for the per-source failure window ban block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PER_SOURCE_FAILURE_WINDOW_BAN_ASSERT_SVH
`define PER_SOURCE_FAILURE_WINDOW_BAN_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define PFWB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfwb: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define PFWB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfwb: next-cycle check failed");
`else
`define PFWB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PFWB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/pfwb_pkg.sv
// Package for the per-source failure window ban block: sizes, payload types,
// register indexes and the sequencer state type. No dependencies.
package pfwb_pkg;

    // Table geometry.
    localparam int SOURCE_SLOTS     = 64;
    localparam int TIMES_PER_SOURCE = 16;

    localparam int SLOT_W  = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int FILL_W  = $clog2(SOURCE_SLOTS + 1);
    localparam int POS_W   = (TIMES_PER_SOURCE > 1) ? $clog2(TIMES_PER_SOURCE) : 1;
    localparam int SUM_W   = $clog2(2 * TIMES_PER_SOURCE);
    localparam int CNT_W   = $clog2(TIMES_PER_SOURCE + 1);
    localparam int TADDR_W = $clog2(SOURCE_SLOTS * TIMES_PER_SOURCE);

    // Field and register widths.
    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 32;
    localparam int THR_W   = 5;
    localparam int WIN_W   = 20;
    localparam int WCNT_W  = 5;
    localparam int CFG_W   = 20;
    localparam int CMP_W   = (CNT_W > THR_W) ? CNT_W : THR_W;

    // Register indexes on the configuration port.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_BAN_THRESHOLD = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

    // Register reset values.
    localparam logic [THR_W-1:0] THR_RESET = 5'd5;
    localparam logic [WIN_W-1:0] WIN_RESET = 20'd600;

    // One failed-login request.
    typedef struct packed {
        logic [ADDR_W-1:0] source_address;
        logic [TIME_W-1:0] event_time;
    } t_request;

    // One result.
    typedef struct packed {
        logic [WCNT_W-1:0] window_count;
        logic              is_banned;
        logic              newly_banned;
        logic              table_full;
        logic              ring_saturated;
    } t_result;

    // One row of the source table.
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              banned;
        logic [POS_W-1:0]  head;
        logic [CNT_W-1:0]  count;
    } t_slot_entry;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_FINISH,
        ST_DROP
    } t_state;

endpackage

FILE: design/per_source_failure_window_ban.sv
// Per-source failure window ban: top level with the slot scan, ring update and
// eviction sequencer. Depends on pfwb_pkg and per_source_failure_window_ban_assert.svh.
//
// One request is taken when start is high and busy is low; busy then stays high
// until the request is finished, and its single result appears on o_result for
// exactly one cycle with o_result_valid high. The receiver cannot stall, so the
// result must be captured in that cycle; a new request may be started in the
// same cycle the result is shown. The time from start to result grows with N,
// the number of sources tracked so far (up to 64, one table row read and
// compared per cycle through the slot memory port), and with K, the number of
// stored times inspected at the old end of the ring (1 to 16, one read and one
// compare of the time memory per inspection). Slots are allocated in order and
// never freed, so the table needs no clearing pass.
`include "per_source_failure_window_ban_assert.svh"

module per_source_failure_window_ban
    import pfwb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_request             i_request,
    output logic                 busy,
    output logic                 o_result_valid,
    output t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    // Advance a ring position by one with wrap.
    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] res;
        if (pos == POS_W'(TIMES_PER_SOURCE - 1)) begin
            res = '0;
        end else begin
            res = pos + POS_W'(1);
        end
        return res;
    endfunction

    t_state               r_state, n_state;
    t_request             r_req;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic [FILL_W-1:0]    r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [SLOT_W-1:0]    r_pend_idx, n_pend_idx;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [POS_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_banned, n_banned;
    logic                 r_sat, n_sat;
    logic [TIME_W-1:0]    r_cutoff, n_cutoff;
    logic                 r_out_valid, n_out_valid;
    t_result              r_result, n_result;
    logic [THR_W-1:0]     r_thr;
    logic [WIN_W-1:0]     r_window;

    // Source table memory and failure time memory.
    t_slot_entry          slot_mem [SOURCE_SLOTS];
    t_slot_entry          r_slot_q;
    logic [TIME_W-1:0]    time_mem [SOURCE_SLOTS * TIMES_PER_SOURCE];
    logic [TIME_W-1:0]    r_time_q;

    logic                 slot_we;
    t_slot_entry          slot_wentry;
    logic [SLOT_W-1:0]    slot_rd_addr;
    logic                 time_we;
    logic [POS_W-1:0]     time_pos;
    logic [TADDR_W-1:0]   time_addr;

    logic                 accept;
    logic                 issue;
    logic                 hit;
    logic                 scan_done;
    logic                 ring_full;
    logic [SUM_W-1:0]     pos_sum;
    logic [POS_W-1:0]     app_pos;
    logic                 thr_hit;
    logic                 newly;
    logic                 banned_next;
    logic                 evict_old;

    assign accept = start && !busy;

    // Scan status: a read is issued while unscanned tracked slots remain.
    assign issue     = (r_idx < r_fill);
    assign hit       = r_pend && (r_slot_q.address == r_req.source_address);
    assign scan_done = !r_pend && !issue;

    // Ring position for the new time: overwrite the oldest when full.
    assign ring_full = (r_count == CNT_W'(TIMES_PER_SOURCE));
    assign pos_sum   = SUM_W'(r_head) + SUM_W'(r_count);
    always_comb begin
        if (ring_full) begin
            app_pos = r_head;
        end else if (pos_sum >= SUM_W'(TIMES_PER_SOURCE)) begin
            app_pos = POS_W'(pos_sum - SUM_W'(TIMES_PER_SOURCE));
        end else begin
            app_pos = POS_W'(pos_sum);
        end
    end

    // Ban decision at the end of the request.
    assign thr_hit     = (CMP_W'(r_count) >= CMP_W'(r_thr));
    assign newly       = thr_hit && !r_banned;
    assign banned_next = r_banned || newly;
    assign evict_old   = (r_time_q < r_cutoff);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_state = ST_APPEND;
                end else if (scan_done) begin
                    n_state = (r_fill == FILL_W'(SOURCE_SLOTS)) ? ST_DROP : ST_APPEND;
                end
            end
            ST_APPEND: begin
                n_state = ST_EVICT_RD;
            end
            ST_EVICT_RD: begin
                n_state = (r_count == '0) ? ST_FINISH : ST_EVICT_CHK;
            end
            ST_EVICT_CHK: begin
                n_state = evict_old ? ST_EVICT_RD : ST_FINISH;
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            ST_DROP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: memory controls and next datapath values.
    always_comb begin
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_idx[SLOT_W-1:0];
        n_slot      = r_slot;
        n_head      = r_head;
        n_count     = r_count;
        n_banned    = r_banned;
        n_sat       = r_sat;
        n_cutoff    = r_cutoff;
        n_out_valid = 1'b0;
        n_result    = r_result;
        slot_we     = 1'b0;
        slot_wentry = '{address: r_req.source_address, banned: banned_next,
                        head: r_head, count: r_count};
        slot_rd_addr = r_idx[SLOT_W-1:0];
        time_we     = 1'b0;
        time_pos    = r_head;
        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                n_sat = 1'b0;
            end
            ST_SCAN: begin
                // One table row is read per cycle and compared the cycle after.
                n_pend = issue && !hit;
                if (issue) begin
                    n_idx = r_idx + FILL_W'(1);
                end
                if (hit) begin
                    n_slot   = r_pend_idx;
                    n_head   = r_slot_q.head;
                    n_count  = r_slot_q.count;
                    n_banned = r_slot_q.banned;
                end else if (scan_done && (r_fill != FILL_W'(SOURCE_SLOTS))) begin
                    // New source: take the next free slot.
                    n_slot   = r_fill[SLOT_W-1:0];
                    n_head   = '0;
                    n_count  = '0;
                    n_banned = 1'b0;
                    n_fill   = r_fill + FILL_W'(1);
                end
            end
            ST_APPEND: begin
                // Store the event time and compute the window start.
                time_we  = 1'b1;
                time_pos = app_pos;
                if (ring_full) begin
                    n_head = pos_inc(r_head);
                    n_sat  = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
                if (r_req.event_time > TIME_W'(r_window)) begin
                    n_cutoff = r_req.event_time - TIME_W'(r_window);
                end else begin
                    n_cutoff = '0;
                end
            end
            ST_EVICT_RD: begin
                time_pos = r_head;
            end
            ST_EVICT_CHK: begin
                // Drop the oldest time when it lies before the window.
                if (evict_old) begin
                    n_head  = pos_inc(r_head);
                    n_count = r_count - CNT_W'(1);
                end
            end
            ST_FINISH: begin
                slot_we     = 1'b1;
                n_banned    = banned_next;
                n_out_valid = 1'b1;
                n_result    = '{window_count: WCNT_W'(r_count), is_banned: banned_next,
                                newly_banned: newly, table_full: 1'b0,
                                ring_saturated: r_sat};
            end
            ST_DROP: begin
                n_out_valid = 1'b1;
                n_result    = '{window_count: '0, is_banned: 1'b0, newly_banned: 1'b0,
                                table_full: 1'b1, ring_saturated: 1'b0};
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    assign time_addr = TADDR_W'(r_slot) * TADDR_W'(TIMES_PER_SOURCE) + TADDR_W'(time_pos);

    // Source table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[r_slot] <= slot_wentry;
        end
        r_slot_q <= slot_mem[slot_rd_addr];
    end

    // Failure time memory with registered read.
    always_ff @(posedge i_clk) begin
        if (time_we) begin
            time_mem[time_addr] <= r_req.event_time;
        end
        r_time_q <= time_mem[time_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= THR_RESET;
            r_window <= WIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BAN_THRESHOLD: r_thr    <= i_cfg_wdata[THR_W-1:0];
                REG_WINDOW_LENGTH: r_window <= i_cfg_wdata[WIN_W-1:0];
                default:           r_thr    <= r_thr;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_request;
        end
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_slot     <= n_slot;
        r_head     <= n_head;
        r_count    <= n_count;
        r_banned   <= n_banned;
        r_sat      <= n_sat;
        r_cutoff   <= n_cutoff;
        r_result   <= n_result;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

    // Checks on the sequencer and the result. The ring count is loaded at the
    // end of the scan, so it is only checked once the scan is over.
    `PFWB_ASSERT_NEXT(a_start_sets_busy, i_clk, i_rst_n, accept, busy)
    `PFWB_ASSERT_SAME(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(SOURCE_SLOTS))
    `PFWB_ASSERT_SAME(a_count_bounded, i_clk, i_rst_n,
                      busy && (r_state != ST_SCAN), r_count <= CNT_W'(TIMES_PER_SOURCE))
    `PFWB_ASSERT_SAME(a_full_result_clean, i_clk, i_rst_n,
                      o_result_valid && o_result.table_full,
                      o_result.window_count == '0 && !o_result.is_banned &&
                      !o_result.ring_saturated)
    `PFWB_ASSERT_SAME(a_newly_implies_banned, i_clk, i_rst_n,
                      o_result_valid && o_result.newly_banned, o_result.is_banned)

endmodule

FILE: verif/tb_per_source_failure_window_ban.sv
// Self-checking testbench for per_source_failure_window_ban: directed and random failed-login
// requests, register changes between phases, results checked against an in-bench ban model.
// Depends on pfwb_pkg and the per_source_failure_window_ban top level.
module tb_per_source_failure_window_ban;
    import pfwb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SIZE   = 48;
    localparam int HOT_COUNT   = 6;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 200;
    localparam int PRINT_LIMIT = 50;

    // One entry of the send queue: either a failure request or a register write.
    typedef struct {
        logic                 is_reg_write;
        t_request             failure;
        logic [REG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_word;
    } t_send_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    t_request             req_bus = '0;
    logic                 busy;
    logic                 o_result_valid;
    t_result              verdict_bus;
    logic                 cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = REG_BAN_THRESHOLD;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    t_send_item        send_q[$];
    t_result           verdicts_due[$];
    int                outstanding = 0;
    int                sent_count = 0;
    int                mismatches = 0;
    int                stall_cycles = 0;
    longint unsigned   gen_now = 0;
    logic [ADDR_W-1:0] src_pool [POOL_SIZE];

    // Ban model: its own copy of the registers and the source table.
    logic [THR_W-1:0]  thr_now = THR_RESET;
    logic [WIN_W-1:0]  win_now = WIN_RESET;
    logic              src_used   [SOURCE_SLOTS];
    logic              src_banned [SOURCE_SLOTS];
    logic [ADDR_W-1:0] src_addr   [SOURCE_SLOTS];
    int                src_head   [SOURCE_SLOTS];
    int                src_fill   [SOURCE_SLOTS];
    logic [TIME_W-1:0] ring_time  [SOURCE_SLOTS][TIMES_PER_SOURCE];

    per_source_failure_window_ban DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_request      (req_bus),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (verdict_bus),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Print one mismatch line (the first few only) and count it.
    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [4:0] seen,
                                 input logic [4:0] want_v);
        if (seen !== want_v) begin
            flag_mismatch($sformatf("%s got %0d, want %0d", name, seen, want_v));
        end
    endtask

    // Find or allocate the slot, append the time, evict old times, update the ban.
    function automatic t_result ban_verdict(input t_request r);
        t_result           v;
        int                slot;
        int                free_slot;
        int                i;
        int                h;
        int                n;
        logic [TIME_W-1:0] win32;
        logic [TIME_W-1:0] cutoff;
        v = '0;
        slot = -1;
        free_slot = -1;
        for (i = 0; i < SOURCE_SLOTS; i++) begin
            if (src_used[i]) begin
                if (slot < 0 && src_addr[i] == r.source_address) slot = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (slot < 0) begin
            // A new source with no room left is dropped.
            if (free_slot < 0) begin
                v.table_full = 1'b1;
                return v;
            end
            slot = free_slot;
            src_used[slot]   = 1'b1;
            src_addr[slot]   = r.source_address;
            src_banned[slot] = 1'b0;
            src_head[slot]   = 0;
            src_fill[slot]   = 0;
        end
        h = src_head[slot];
        n = src_fill[slot];
        if (n == TIMES_PER_SOURCE) begin
            ring_time[slot][h] = r.event_time;
            h = (h + 1) % TIMES_PER_SOURCE;
            v.ring_saturated = 1'b1;
        end else begin
            ring_time[slot][(h + n) % TIMES_PER_SOURCE] = r.event_time;
            n++;
        end
        win32 = TIME_W'(win_now);
        cutoff = (r.event_time > win32) ? r.event_time - win32 : '0;
        // Eviction looks only at the oldest end and stops at the first time in the window.
        while (n > 0 && ring_time[slot][h] < cutoff) begin
            h = (h + 1) % TIMES_PER_SOURCE;
            n--;
        end
        src_head[slot] = h;
        src_fill[slot] = n;
        if (n >= int'(thr_now) && !src_banned[slot]) begin
            src_banned[slot] = 1'b1;
            v.newly_banned = 1'b1;
        end
        v.window_count = WCNT_W'(n);
        v.is_banned = src_banned[slot];
        return v;
    endfunction

    task automatic queue_failure(input logic [ADDR_W-1:0] src, input logic [TIME_W-1:0] at);
        t_send_item it;
        it.is_reg_write = 1'b0;
        it.failure.source_address = src;
        it.failure.event_time = at;
        it.reg_index = REG_BAN_THRESHOLD;
        it.reg_word = '0;
        send_q = {send_q, it};
    endtask

    task automatic queue_reg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] word);
        t_send_item it;
        it.is_reg_write = 1'b1;
        it.failure = '0;
        it.reg_index = idx;
        it.reg_word = word;
        send_q = {send_q, it};
    endtask

    // Move the generator clock forward, never past the largest time.
    task automatic advance_clock(input longint unsigned step);
        gen_now = gen_now + step;
        if (gen_now > 64'hFFFF_FFFF) gen_now = 64'hFFFF_FFFF;
    endtask

    // One random phase: set both registers, then mostly a few busy sources with
    // times that creep forward, plus stray sources, late times and long jumps.
    task automatic queue_phase(input logic [CFG_W-1:0] thr_word, input logic [WIN_W-1:0] win_len,
                               input int n_items);
        int                hot [HOT_COUNT];
        int                k;
        int                roll;
        longint unsigned   span;
        longint unsigned   back;
        logic [ADDR_W-1:0] src;
        logic [TIME_W-1:0] at;
        queue_reg_write(REG_BAN_THRESHOLD, thr_word);
        queue_reg_write(REG_WINDOW_LENGTH, win_len);
        if ($urandom_range(0, 2) == 0) gen_now = 64'($urandom);
        for (k = 0; k < HOT_COUNT; k++) hot[k] = $urandom_range(2, POOL_SIZE - 1);
        span = win_len / ($urandom_range(0, 1) ? 8 : 64) + 1;
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 85) begin
                src = src_pool[hot[$urandom_range(0, HOT_COUNT - 1)]];
            end else begin
                src = src_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                // A time a little behind the running clock.
                back = 64'($urandom_range(0, win_len));
                at = (back > gen_now) ? '0 : TIME_W'(gen_now - back);
            end else begin
                if (roll < 8) begin
                    advance_clock(win_len + 1 + $urandom_range(0, win_len));
                end else begin
                    advance_clock($urandom_range(0, span));
                end
                at = TIME_W'(gen_now);
            end
            queue_failure(src, at);
        end
    endtask

    // Driver: presents the head of the send queue; register writes wait for an idle block.
    always @(posedge i_clk) begin : drive_requests
        t_send_item           head;
        logic                 nxt_start;
        logic                 nxt_we;
        t_request             nxt_req;
        logic [REG_IDX_W-1:0] nxt_idx;
        logic [CFG_W-1:0]     nxt_data;
        if (!i_rst_n) begin
            start     <= 1'b0;
            req_bus   <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= REG_BAN_THRESHOLD;
            cfg_wdata <= '0;
        end else begin
            nxt_start = 1'b0;
            nxt_we    = 1'b0;
            nxt_req   = req_bus;
            nxt_idx   = cfg_index;
            nxt_data  = cfg_wdata;
            if (start && !busy) begin
                void'(send_q.pop_front());
                sent_count++;
            end
            if (send_q.size() > 0) begin
                head = send_q[0];
                if (head.is_reg_write) begin
                    if (!start && !busy && outstanding == 0) begin
                        nxt_we   = 1'b1;
                        nxt_idx  = head.reg_index;
                        nxt_data = head.reg_word;
                        void'(send_q.pop_front());
                    end
                end else if ((sent_count >= 300 && sent_count < 500) ||
                             $urandom_range(0, 99) >= 10) begin
                    nxt_start = 1'b1;
                    nxt_req   = head.failure;
                end
            end
            start     <= nxt_start;
            req_bus   <= nxt_req;
            cfg_we    <= nxt_we;
            cfg_index <= nxt_idx;
            cfg_wdata <= nxt_data;
        end
    end

    // Monitor: checks each result, tracks register writes and predicts accepted requests.
    always @(posedge i_clk) begin : watch_results
        t_result want;
        int      took;
        int      got;
        int      i;
        if (!i_rst_n) begin
            outstanding <= 0;
            thr_now = THR_RESET;
            win_now = WIN_RESET;
            for (i = 0; i < SOURCE_SLOTS; i++) begin
                src_used[i]   = 1'b0;
                src_banned[i] = 1'b0;
                src_head[i]   = 0;
                src_fill[i]   = 0;
            end
        end else begin
            took = 0;
            got  = 0;
            if (o_result_valid) begin
                if (verdicts_due.size() == 0) begin
                    flag_mismatch("result with no request pending");
                end else begin
                    want = verdicts_due.pop_front();
                    got = 1;
                    compare_field("window_count", verdict_bus.window_count, want.window_count);
                    compare_field("is_banned", verdict_bus.is_banned, want.is_banned);
                    compare_field("newly_banned", verdict_bus.newly_banned, want.newly_banned);
                    compare_field("table_full", verdict_bus.table_full, want.table_full);
                    compare_field("ring_saturated", verdict_bus.ring_saturated,
                                  want.ring_saturated);
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_BAN_THRESHOLD) begin
                    thr_now = cfg_wdata[THR_W-1:0];
                end else if (cfg_index == REG_WINDOW_LENGTH) begin
                    win_now = cfg_wdata[WIN_W-1:0];
                end
            end
            if (start && !busy) begin
                verdicts_due = {verdicts_due, ban_verdict(req_bus)};
                took = 1;
            end
            outstanding <= outstanding + took - got;
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_result_valid || cfg_we) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int                k;
        logic [CFG_W-1:0]  word;
        logic [WIN_W-1:0]  win_len;
        logic [ADDR_W-1:0] src;

        src_pool[0] = '0;
        src_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++) src_pool[k] = $urandom;

        // Directed part under the reset register values: extreme fields, a
        // late time that stays behind a newer head, and a window longer than
        // the event time.
        queue_failure(src_pool[0], 32'h0000_0000);
        queue_failure(src_pool[1], 32'hFFFF_FFFF);
        queue_failure(src_pool[2], 32'd2000);
        queue_failure(src_pool[2], 32'd1000);
        queue_failure(src_pool[2], 32'd2500);
        queue_failure(src_pool[3], 32'd10);

        // Threshold sixteen and the largest window: a full ring, a ban at sixteen, then overwrite.
        queue_reg_write(REG_BAN_THRESHOLD, CFG_W'(16));
        queue_reg_write(REG_WINDOW_LENGTH, '1);
        for (k = 0; k < TIMES_PER_SOURCE + 1; k++) queue_failure(src_pool[4], 32'd5000);

        // Threshold zero bans on the first event.
        queue_reg_write(REG_BAN_THRESHOLD, CFG_W'(0));
        queue_failure(src_pool[5], 32'd7000);

        // Random phases, the extreme settings first.
        gen_now = 64'd8000;
        queue_phase(CFG_W'(1), '0, 100);
        queue_phase(CFG_W'(31), WIN_W'(1000), 100);
        queue_phase(CFG_W'(16), '1, 100);
        queue_phase(CFG_W'(3), WIN_W'(60), 100);
        queue_phase(CFG_W'(5), WIN_W'(600), 100);
        queue_phase(CFG_W'(0), WIN_W'(5), 100);
        for (k = 0; k < 4; k++) begin
            word = CFG_W'($urandom);
            word[THR_W-1:0] = THR_W'($urandom_range(2, 16));
            win_len = ($urandom_range(0, 3) == 0) ? WIN_W'($urandom) :
                                                    WIN_W'($urandom_range(1, 2000));
            queue_phase(word, win_len, 80);
        end

        // Last phase: fresh sources fill the table, after which new ones are dropped.
        queue_reg_write(REG_BAN_THRESHOLD, CFG_W'(3));
        queue_reg_write(REG_WINDOW_LENGTH, WIN_W'(600));
        for (k = 0; k < 100; k++) begin
            src = ($urandom_range(0, 99) < 75) ? ADDR_W'($urandom) :
                                                 src_pool[$urandom_range(0, 7)];
            advance_clock($urandom_range(0, 40));
            queue_failure(src, TIME_W'(gen_now));
        end

        // Drain: every request sent and answered, then a quiet tail.
        do begin
            @(negedge i_clk);
        end while (send_q.size() != 0 || start || outstanding != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (verdicts_due.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", verdicts_due.size()));
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/pfwb_pkg.sv
design/per_source_failure_window_ban.sv
verif/tb_per_source_failure_window_ban.sv
